// ===== hdl/skts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skts_pkg
// Types and codes shared by the sorted key table search modules.
// ----------------------------------------------------------------------------
package skts_pkg;

    localparam int KeyWidth = 64;
    localparam int DivCountWidth = 6;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [KeyWidth-1:0] key;
    } skts_item_t;

    typedef struct packed {
        logic        found;
        logic [9:0]  match_index;
        logic [3:0]  binary_probes;
        logic [10:0] modulo_probes;
    } skts_result_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_B_CHECK,
        OP_B_CMP,
        OP_M_RDH,
        OP_M_RDL,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_M_RDP,
        OP_M_CMP
    } skts_op_t;

    typedef struct packed {
        skts_op_t op;
    } skts_cmd_t;

    typedef struct packed {
        logic in_query;
        logic empty;
        logic b_range_empty;
        logic b_hit;
        logic div_last;
        logic m_stop;
    } skts_status_t;

endpackage
`default_nettype wire

// ===== hdl/skts_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module skts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/skts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skts_ctrl
// Sequencer for append, clear and the two searches of a query.
// ----------------------------------------------------------------------------
module skts_ctrl
    import skts_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire skts_status_t status,
    output skts_cmd_t         cmd,
    output logic              busy,
    output logic              done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_B_CHECK,
        S_B_CMP,
        S_M_RDH,
        S_M_RDL,
        S_DIV_START,
        S_DIV_STEP,
        S_M_RDP,
        S_M_CMP,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;

    // command decode and next state
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_LOAD;
                    if (status.in_query)
                    begin
                        state_next = status.empty ? S_RESULT : S_B_CHECK;
                    end
                end
            end
            S_B_CHECK:
            begin
                cmd.op     = OP_B_CHECK;
                state_next = status.b_range_empty ? S_M_RDH : S_B_CMP;
            end
            S_B_CMP:
            begin
                cmd.op     = OP_B_CMP;
                state_next = status.b_hit ? S_M_RDH : S_B_CHECK;
            end
            S_M_RDH:
            begin
                cmd.op     = OP_M_RDH;
                state_next = S_M_RDL;
            end
            S_M_RDL:
            begin
                cmd.op     = OP_M_RDL;
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                cmd.op     = OP_DIV_START;
                state_next = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                cmd.op = OP_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = S_M_RDP;
                end
            end
            S_M_RDP:
            begin
                cmd.op     = OP_M_RDP;
                state_next = S_M_CMP;
            end
            S_M_CMP:
            begin
                cmd.op     = OP_M_CMP;
                state_next = status.m_stop ? S_RESULT : S_M_RDH;
            end
            S_RESULT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESULT);

endmodule
`default_nettype wire

// ===== hdl/skts_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skts_datapath
// Key table, search bounds, probe counters and serial remainder unit.
// ----------------------------------------------------------------------------
module skts_datapath
    import skts_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire skts_item_t item,
    input  wire skts_cmd_t  cmd,
    output skts_status_t    status,
    output skts_result_t    result
);

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int BPW = $clog2(CW + 2);
    localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

    logic [CW-1:0]       count_reg;
    logic [KeyWidth-1:0] key_reg;

    // binary search state, upper bound kept as hi + 1
    logic [CW-1:0]  b_lo_reg, b_hi1_reg;
    logic [AW-1:0]  b_mid_reg;
    logic [BPW-1:0] b_cnt_reg;
    logic           found_reg;
    logic [AW-1:0]  idx_reg;

    // modulo search state
    logic [AW-1:0]       m_lo_reg, m_hi_reg, m_p_reg;
    logic [CW-1:0]       m_cnt_reg;
    logic [KeyWidth-1:0] khi_reg;
    logic [KeyWidth-1:0] dividend_reg;
    logic [CW-1:0]       rem_reg;
    logic [DivCountWidth-1:0] div_cnt_reg;

    logic                we;
    logic [AW-1:0]       raddr;
    logic [KeyWidth-1:0] rdata;
    logic [CW-1:0]       b_mid;
    logic [CW-1:0]       span;
    logic [CW:0]         trial;
    logic [CW:0]         trial_sub;
    logic [AW-1:0]       p_calc;
    logic                v_gt, v_eq;

    // key table
    skts_ram #(
        .WIDTH (KeyWidth),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata (item.key),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign we = (cmd.op == OP_LOAD) && (item.kind == KIND_APPEND) && (count_reg < DepthC);

    // search arithmetic
    assign b_mid     = b_lo_reg + ((b_hi1_reg - b_lo_reg - CW'(1)) >> 1);
    assign span      = CW'(m_hi_reg) - CW'(m_lo_reg) + CW'(1);
    assign trial     = {rem_reg, dividend_reg[KeyWidth-1]};
    assign trial_sub = trial - {1'b0, span};
    assign p_calc    = m_lo_reg + rem_reg[AW-1:0];
    assign v_eq      = (rdata == key_reg);
    assign v_gt      = (rdata > key_reg);

    // read address select
    always_comb
    begin
        unique case (cmd.op)
            OP_B_CHECK: raddr = b_mid[AW-1:0];
            OP_M_RDH:   raddr = m_hi_reg;
            OP_M_RDL:   raddr = m_lo_reg;
            OP_M_RDP:   raddr = p_calc;
            default:    raddr = m_p_reg;
        endcase
    end

    // status to the sequencer
    always_comb
    begin
        status.in_query      = (item.kind == KIND_QUERY);
        status.empty         = (count_reg == '0);
        status.b_range_empty = (b_lo_reg >= b_hi1_reg);
        status.b_hit         = v_eq;
        status.div_last      = (div_cnt_reg == '1);
        status.m_stop        = v_eq || (m_lo_reg == m_hi_reg)
                               || (v_gt && (m_p_reg == m_lo_reg))
                               || (!v_gt && (m_p_reg == m_hi_reg));
    end

    // entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.op == OP_LOAD)
        begin
            if (item.kind == KIND_CLEAR)
            begin
                count_reg <= '0;
            end
            else if (we)
            begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    // search registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                key_reg   <= item.key;
                b_lo_reg  <= '0;
                b_hi1_reg <= count_reg;
                b_cnt_reg <= '0;
                found_reg <= 1'b0;
                idx_reg   <= '0;
                m_lo_reg  <= '0;
                m_hi_reg  <= AW'(count_reg - CW'(1));
                m_cnt_reg <= '0;
            end
            OP_B_CHECK:
            begin
                b_cnt_reg <= b_cnt_reg + BPW'(1);
                b_mid_reg <= b_mid[AW-1:0];
            end
            OP_B_CMP:
            begin
                if (v_eq)
                begin
                    found_reg <= 1'b1;
                    idx_reg   <= b_mid_reg;
                end
                else if (v_gt)
                begin
                    b_hi1_reg <= CW'(b_mid_reg);
                end
                else
                begin
                    b_lo_reg <= CW'(b_mid_reg) + CW'(1);
                end
            end
            OP_M_RDL:
            begin
                khi_reg <= rdata;
            end
            OP_DIV_START:
            begin
                dividend_reg <= khi_reg - rdata;
                rem_reg      <= '0;
                div_cnt_reg  <= '0;
            end
            OP_DIV_STEP:
            begin
                // one restoring remainder bit per cycle
                dividend_reg <= {dividend_reg[KeyWidth-2:0], 1'b0};
                div_cnt_reg  <= div_cnt_reg + DivCountWidth'(1);
                if (trial >= {1'b0, span})
                begin
                    rem_reg <= trial_sub[CW-1:0];
                end
                else
                begin
                    rem_reg <= trial[CW-1:0];
                end
            end
            OP_M_RDP:
            begin
                m_p_reg <= p_calc;
            end
            OP_M_CMP:
            begin
                m_cnt_reg <= m_cnt_reg + CW'(1);
                if (v_gt)
                begin
                    m_hi_reg <= m_p_reg - AW'(1);
                end
                else
                begin
                    m_lo_reg <= m_p_reg + AW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // result fields, masked to their widths
    assign result.found         = found_reg;
    assign result.match_index   = 10'(32'(idx_reg));
    assign result.binary_probes = 4'(32'(b_cnt_reg));
    assign result.modulo_probes = 11'(32'(m_cnt_reg));

endmodule
`default_nettype wire

// ===== hdl/sorted_key_table_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table_search
// Sorted 64-bit key table with binary and modulo-probe searches.
// ----------------------------------------------------------------------------
// An item is taken on a clock edge with start high and busy low. Its kind
// appends the key, clears the table, or queries the key; kind 3 is dropped.
// Append and clear leave busy low and give no result. A query runs a
// binary search (a check state then a compare state for each probe) and
// then a modulo-probe search; each modulo probe makes three table reads
// through the single RAM read port and runs the bit-serial 64-bit remainder
// unit. An empty table skips both searches and goes straight to the result.
// busy stays high until the result is shown. The result is on result for
// the one cycle in which done is high; the receiver cannot stall, so it
// must take it then. Reset empties the table at once; table contents are
// not cleared and entries past the count are never read.
// ----------------------------------------------------------------------------
module sorted_key_table_search
    import skts_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire skts_item_t item,
    output logic            busy,
    output logic            done,
    output skts_result_t    result
);

    skts_cmd_t    cmd;
    skts_status_t status;

    // sequencer
    skts_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // table and search datapath
    skts_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

    // a result only appears while busy is high
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done without busy");

    // results are single cycle strobes
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held longer than one cycle");

    // append, clear and unknown kinds give no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.kind != KIND_QUERY)) |=> (!busy && !done))
        else $error("non-query item produced activity");

endmodule
`default_nettype wire
